// File: hw/rtl/jpd_pkg.sv
// Shared constants and the arctangent table for the joystick polar deadzone block.
// No dependencies; every RTL file but jpd_delay refers to this package by scoped name.
`timescale 1ns / 1ps

package jpd_pkg;

	localparam int FULL_SCALE   = 32767;
	localparam int SQRT_BITS    = 23;   // floor(sqrt(r2 * 65536)) stays below 2^23
	localparam int RAD_W        = 2 * SQRT_BITS;
	localparam int MAG_BITS     = 17;
	localparam int ATAN_ENTRIES = 24;
	localparam int CX_W         = 33;
	localparam int Z_W          = 25;

	localparam logic [31:0]    FULL_SQ  = 32'd1073676289;  // 32767 squared
	localparam logic [Z_W-1:0] DEG_90   = 25'd5898240;
	localparam logic [Z_W-1:0] DEG_180  = 25'd11796480;
	localparam logic [Z_W-1:0] DEG_360  = 25'd23592960;
	localparam logic [MAG_BITS-1:0] MAG_FULL = 17'd65536;

	// atan(2^-i) in degrees * 65536, rounded
	function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			0:  v = 25'sd2949120;
			1:  v = 25'sd1740967;
			2:  v = 25'sd919879;
			3:  v = 25'sd466945;
			4:  v = 25'sd234379;
			5:  v = 25'sd117304;
			6:  v = 25'sd58666;
			7:  v = 25'sd29335;
			8:  v = 25'sd14668;
			9:  v = 25'sd7334;
			10: v = 25'sd3667;
			11: v = 25'sd1833;
			12: v = 25'sd917;
			13: v = 25'sd458;
			14: v = 25'sd229;
			15: v = 25'sd115;
			16: v = 25'sd57;
			17: v = 25'sd29;
			18: v = 25'sd14;
			19: v = 25'sd7;
			20: v = 25'sd4;
			21: v = 25'sd2;
			22: v = 25'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/jpd_delay.sv
// Shift register that carries side data alongside the pipeline.
// Depends on nothing; advances on the shared pipeline enable.
`timescale 1ns / 1ps

module jpd_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             advance,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (advance) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

// File: hw/rtl/jpd_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on jpd_pkg for widths.
`timescale 1ns / 1ps

module jpd_sqrt (
	input  logic                          clk,
	input  logic                          advance,
	input  logic [jpd_pkg::RAD_W-1:0]     radicand,
	output logic [jpd_pkg::SQRT_BITS-1:0] root
);

	localparam int RW = jpd_pkg::SQRT_BITS;
	localparam int NW = jpd_pkg::RAD_W;

	logic [NW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		localparam int K = RW - 1 - j;
		logic [NW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [NW:0]   trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
		end

		// low bits of the partial root are still zero, so OR adds
		always_comb begin
			trial = ((NW+1)'(root_in) << (K + 1)) | ((NW+1)'(1) << (2 * K));
			ge    = {1'b0, rem_in} >= trial;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[j]  <= ge ? (rem_in - trial[NW-1:0]) : rem_in;
				root_s[j] <= ge ? (root_in | (RW'(1) << K)) : root_in;
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

// File: hw/rtl/jpd_div.sv
// Pipelined restoring divider for the magnitude, one quotient bit per stage.
// Depends on jpd_pkg for the quotient width.
`timescale 1ns / 1ps

module jpd_div (
	input  logic                         clk,
	input  logic                         advance,
	input  logic [30:0]                  dividend,
	input  logic [14:0]                  divisor,
	output logic [jpd_pkg::MAG_BITS-1:0] quotient
);

	localparam int QW = jpd_pkg::MAG_BITS;

	logic [30:0]   rem_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [30:0]   rem_in;
		logic [QW-1:0] quo_in;
		logic [31:0]   sub;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in = dividend;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		always_comb begin
			sub = 32'(divisor) << K;
			ge  = {1'b0, rem_in} >= sub;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[j] <= ge ? (rem_in - sub[30:0]) : rem_in;
				quo_s[j] <= ge ? (quo_in | (QW'(1) << K)) : quo_in;
			end
		end
	end

	assign quotient = quo_s[QW-1];

endmodule

// File: hw/rtl/jpd_cordic.sv
// Vectoring CORDIC for the first-quadrant angle, one iteration per stage.
// Depends on jpd_pkg for the arctangent table and widths.
`timescale 1ns / 1ps

module jpd_cordic #(
	parameter int ITERATIONS = 16
) (
	input  logic                             clk,
	input  logic                             advance,
	input  logic [16:0]                      ax,
	input  logic [16:0]                      ay,
	output logic signed [jpd_pkg::Z_W-1:0]   angle
);

	localparam int CW = jpd_pkg::CX_W;
	localparam int ZW = jpd_pkg::Z_W;

	logic signed [CW-1:0] cx_s [ITERATIONS];
	logic signed [CW-1:0] cy_s [ITERATIONS];
	logic signed [ZW-1:0] z_s  [ITERATIONS];

	for (genvar j = 0; j < ITERATIONS; j++) begin : g_stage
		logic signed [CW-1:0] cx_in, cy_in, dx, dy;
		logic signed [ZW-1:0] z_in;

		if (j == 0) begin : g_first
			assign cx_in = $signed(CW'(ax) << 14);
			assign cy_in = $signed(CW'(ay) << 14);
			assign z_in  = '0;
		end else begin : g_next
			assign cx_in = cx_s[j-1];
			assign cy_in = cy_s[j-1];
			assign z_in  = z_s[j-1];
		end

		always_comb begin
			dx = cy_in >>> j;
			dy = cx_in >>> j;
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (advance) begin
				if (cy_in > 0) begin
					cx_s[j] <= cx_in + dx;
					cy_s[j] <= cy_in - dy;
					z_s[j]  <= z_in + jpd_pkg::atan_deg(j);
				end else begin
					cx_s[j] <= cx_in - dx;
					cy_s[j] <= cy_in + dy;
					z_s[j]  <= z_in - jpd_pkg::atan_deg(j);
				end
			end
		end
	end

	assign angle = z_s[ITERATIONS-1];

endmodule

// File: hw/rtl/joystick_polar_deadzone.sv
// The latency from an accepted sample to its result is the same for any iteration count.
// Throughput: one sample per cycle unless a result is stalled; the square root and divider
// pipelines (one bit per stage) set the depth, the CORDIC runs beside them.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the deadzone radius with 7849.
// Depends on jpd_pkg, jpd_delay, jpd_sqrt, jpd_div and jpd_cordic.
`timescale 1ns / 1ps

module joystick_polar_deadzone #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] x_position,
	input  logic signed [15:0] y_position,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [16:0]        angle_deg,
	output logic [16:0]        magnitude,
	output logic               in_deadzone,
	input  logic               config_valid,
	output logic               config_ready,
	input  logic [14:0]        config_data
);

	localparam int SQ  = jpd_pkg::SQRT_BITS;
	localparam int QW  = jpd_pkg::MAG_BITS;
	localparam int LAT = 2 + SQ + 1 + QW + 1;
	localparam int ZW  = jpd_pkg::Z_W;

	logic advance;
	logic [LAT-1:0] valid_q;

	// configuration and values derived from it
	logic [14:0] dz_q;
	logic [29:0] dzsq_q;
	logic [14:0] divisor_q;
	logic        dzfull_q;

	assign config_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= 15'd7849;
		end else if (config_valid) begin
			dz_q <= config_data;
		end
	end

	always_ff @(posedge clk) begin
		dzsq_q    <= 30'(dz_q) * 30'(dz_q);
		divisor_q <= 15'(jpd_pkg::FULL_SCALE) - dz_q;
		dzfull_q  <= dz_q == 15'(jpd_pkg::FULL_SCALE);
	end

	assign advance      = !result_valid || !result_stall;
	assign sample_stall = !advance;
	assign result_valid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[LAT-2:0], sample_valid};
		end
	end

	// stage 1: squares and magnitudes
	logic [30:0] xx_s1, yy_s1;
	logic [16:0] ax_s1, ay_s1;
	logic        xneg_s1, yneg_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			xx_s1   <= 31'(32'(x_position) * 32'(x_position));
			yy_s1   <= 31'(32'(y_position) * 32'(y_position));
			ax_s1   <= x_position[15] ? 17'(~{x_position[15], x_position} + 17'd1)
			                          : {1'b0, x_position};
			ay_s1   <= y_position[15] ? 17'(~{y_position[15], y_position} + 17'd1)
			                          : {1'b0, y_position};
			xneg_s1 <= x_position[15];
			yneg_s1 <= y_position[15];
			zero_s1 <= (x_position == '0) && (y_position == '0);
		end
	end

	// stage 2: radius squared, deadzone test, clamp before the root
	logic [31:0] r2;
	logic [31:0] r2c;
	logic [jpd_pkg::RAD_W-1:0] rad_s2;
	logic dz_s2;

	always_comb begin
		r2  = {1'b0, xx_s1} + {1'b0, yy_s1};
		r2c = (r2 > jpd_pkg::FULL_SQ) ? jpd_pkg::FULL_SQ : r2;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rad_s2 <= {r2c[29:0], 16'b0};
			dz_s2  <= r2 < {2'b0, dzsq_q};
		end
	end

	logic [SQ-1:0] root;
	jpd_sqrt u_sqrt (
		.clk      (clk),
		.advance  (advance),
		.radicand (rad_s2),
		.root     (root)
	);

	// stage after the root: offset by the deadzone
	logic [SQ-1:0] num_s26;
	always_ff @(posedge clk) begin
		if (advance) begin
			num_s26 <= root - {dz_q, 8'b0};
		end
	end

	logic [QW-1:0] quot;
	jpd_div u_div (
		.clk      (clk),
		.advance  (advance),
		.dividend ({num_s26, 8'b0}),
		.divisor  (divisor_q),
		.quotient (quot)
	);

	logic signed [ZW-1:0] z_raw, z_dly;
	jpd_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk     (clk),
		.advance (advance),
		.ax      (ax_s1),
		.ay      (ay_s1),
		.angle   (z_raw)
	);

	jpd_delay #(.WIDTH(ZW), .DEPTH(LAT - 2 - CORDIC_ITERATIONS)) u_zdly (
		.clk     (clk),
		.advance (advance),
		.din     (z_raw),
		.dout    (z_dly)
	);

	logic [2:0] side_dly;
	jpd_delay #(.WIDTH(3), .DEPTH(LAT - 2)) u_sdly (
		.clk     (clk),
		.advance (advance),
		.din     ({xneg_s1, yneg_s1, zero_s1}),
		.dout    (side_dly)
	);

	logic dz_dly;
	jpd_delay #(.WIDTH(1), .DEPTH(LAT - 3)) u_ddly (
		.clk     (clk),
		.advance (advance),
		.din     (dz_s2),
		.dout    (dz_dly)
	);

	// final stage: quadrant mapping, wrap, forcing
	logic [ZW-1:0] a_fq, ang;
	logic xneg, yneg, zero;

	always_comb begin
		{xneg, yneg, zero} = side_dly;
		if (z_dly < 0) begin
			a_fq = '0;
		end else if ($unsigned(z_dly) > jpd_pkg::DEG_90) begin
			a_fq = jpd_pkg::DEG_90;
		end else begin
			a_fq = $unsigned(z_dly);
		end
		priority if (zero) begin
			ang = '0;
		end else if (!xneg && !yneg) begin
			ang = a_fq;
		end else if (xneg && !yneg) begin
			ang = jpd_pkg::DEG_180 - a_fq;
		end else if (xneg) begin
			ang = jpd_pkg::DEG_180 + a_fq;
		end else begin
			ang = jpd_pkg::DEG_360 - a_fq;
		end
		if (ang >= jpd_pkg::DEG_360) begin
			ang = ang - jpd_pkg::DEG_360;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_deadzone <= dz_dly;
			angle_deg   <= dz_dly ? '0 : ang[ZW-1:8];
			magnitude   <= dz_dly ? '0 : (dzfull_q ? jpd_pkg::MAG_FULL : quot);
		end
	end

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_deadzone |-> angle_deg == '0 && magnitude == '0)
		else $error("deadzone result not forced to zero");
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> magnitude <= jpd_pkg::MAG_FULL)
		else $error("magnitude above full scale");
	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> angle_deg < 17'd92160)
		else $error("angle not wrapped below 360 degrees");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking bench for joystick_polar_deadzone: directed corners, deadzone extremes, random phases, hold-off.
// Holds its own polar/deadzone predictor; depends on the block and on jpd_pkg only via the DUT.
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [16:0] angle;
		logic [16:0] mag;
		logic        centered;
	} polar_t;

	localparam int  CORDIC_STEPS = 16;
	localparam int  HOLD_LEN     = 300;
	localparam int  SETTLE       = 60;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint FULL     = 32767;
	localparam longint ONE_DEG  = 65536;
	localparam longint QUARTER  = 90 * ONE_DEG;
	localparam longint HALF     = 180 * ONE_DEG;
	localparam longint TURN     = 360 * ONE_DEG;

	// atan(2^-i) in degrees * 65536
	localparam longint ATAN_TAB [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic signed [15:0] x_position = '0;
	logic signed [15:0] y_position = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [16:0]        angle_deg;
	logic [16:0]        magnitude;
	logic               in_deadzone;
	logic               config_valid = 1'b0;
	logic               config_ready;
	logic [14:0]        config_data = '0;

	polar_t      pending_polar[$];
	logic [14:0] model_deadzone = 15'd7849;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          hold_cycles = 0;
	logic        hold_req = 1'b0;
	longint      cycle_count = 0;

	joystick_polar_deadzone #(.CORDIC_ITERATIONS(CORDIC_STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.x_position(x_position), .y_position(y_position),
		.result_valid(result_valid), .result_stall(result_stall),
		.angle_deg(angle_deg), .magnitude(magnitude), .in_deadzone(in_deadzone),
		.config_valid(config_valid), .config_ready(config_ready),
		.config_data(config_data)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// first-quadrant direction, degrees * 65536, clamped to [0, 90]
	function automatic longint quadrant_angle(input longint ax, input longint ay);
		longint cx, cy, z, dx, dy;
		cx = ax <<< 14;
		cy = ay <<< 14;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx; cy -= dy; z += ATAN_TAB[i];
			end else begin
				cx -= dx; cy += dy; z -= ATAN_TAB[i];
			end
		end
		if (z < 0) z = 0;
		if (z > QUARTER) z = QUARTER;
		return z;
	endfunction

	function automatic polar_t polar_of(input logic signed [15:0] xs,
		input logic signed [15:0] ys, input logic [14:0] dzr);
		polar_t p;
		longint x, y, dz, r2, r256, mag, a, ang;
		x = xs;
		y = ys;
		dz = dzr;
		r2 = x * x + y * y;
		p = '0;
		if (r2 < dz * dz) begin
			p.centered = 1'b1;
			return p;
		end
		if (r2 > FULL * FULL) r256 = FULL << 8;
		else r256 = longint'(int_sqrt(longint'(r2) << 16));
		if (dz >= FULL) begin
			mag = 65536;
		end else begin
			mag = ((r256 - (dz << 8)) << 16) / ((FULL - dz) << 8);
			if (mag > 65536) mag = 65536;
		end
		if (x == 0 && y == 0) begin
			ang = 0;
		end else begin
			a = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
			if (x >= 0 && y >= 0) ang = a;
			else if (x < 0 && y >= 0) ang = HALF - a;
			else if (x < 0) ang = HALF + a;
			else ang = TURN - a;
			if (ang >= TURN) ang -= TURN;
		end
		p.angle = 17'(ang >> 8);
		p.mag = 17'(mag);
		return p;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending",
				cycle_count, pending_polar.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req) hold_cycles <= HOLD_LEN;
		else if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
	end

	always @(posedge clk) begin
		polar_t want;
		if (result_valid && !result_stall) begin
			results_seen++;
			if (pending_polar.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: angle %0d mag %0d dz %0b",
						angle_deg, magnitude, in_deadzone);
			end else begin
				want = pending_polar.pop_front();
				if (angle_deg !== want.angle || magnitude !== want.mag ||
					in_deadzone !== want.centered) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected angle %0d mag %0d dz %0b, got %0d %0d %0b",
							want.angle, want.mag, want.centered,
							angle_deg, magnitude, in_deadzone);
				end
			end
		end
		result_stall <= (hold_cycles != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_sample(input logic signed [15:0] xs, input logic signed [15:0] ys);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		x_position <= xs;
		y_position <= ys;
		do @(posedge clk); while (sample_stall);
		pending_polar.push_back(polar_of(xs, ys, model_deadzone));
	endtask

	task automatic end_burst();
		sample_valid <= 1'b0;
		wait (pending_polar.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_deadzone(input logic [14:0] value);
		end_burst();
		config_valid <= 1'b1;
		config_data <= value;
		do @(posedge clk); while (!config_ready);
		config_valid <= 1'b0;
		model_deadzone = value;
	endtask

	task automatic random_sample();
		int kind;
		logic signed [15:0] xs, ys;
		kind = $urandom_range(9);
		xs = 16'($urandom);
		ys = 16'($urandom);
		if (kind < 3) begin
			// near the deadzone edge
			xs = $signed(16'(model_deadzone)) + $signed(16'($urandom_range(20))) - 16'sd10;
			ys = $signed(16'($urandom_range(40))) - 16'sd20;
			if ($urandom_range(1)) begin xs = -xs; end
		end else if (kind == 3) begin
			if ($urandom_range(1)) ys = '0; else xs = '0;
		end
		send_sample(xs, ys);
	endtask

	task automatic test_directed();
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd0);
		send_sample(-16'sd32768, 16'sd0);
		send_sample(16'sd0, 16'sd32767);
		send_sample(16'sd0, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd9000, 16'sd0);
		send_sample(16'sd7849, 16'sd0);
		send_sample(16'sd7848, 16'sd0);
		send_sample(16'sd5550, 16'sd5550);
		send_sample(16'sd30000, -16'sd1);
		send_sample(16'sd20000, 16'sd20000);
		send_sample(-16'sd1, -16'sd1);
		end_burst();
	endtask

	task automatic test_deadzone_extremes();
		write_deadzone(15'd0);
		send_sample(16'sd0, 16'sd0);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd1, -16'sd1);
		send_sample(16'sd32767, 16'sd32767);
		write_deadzone(15'd32766);
		send_sample(16'sd32767, 16'sd0);
		send_sample(16'sd32765, 16'sd0);
		send_sample(-16'sd32768, 16'sd5);
		write_deadzone(15'd32767);
		send_sample(16'sd32767, 16'sd0);
		send_sample(-16'sd32768, 16'sd0);
		send_sample(16'sd32767, 16'sd32767);
		end_burst();
	endtask

	task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct,
		input logic [14:0] dz);
		write_deadzone(dz);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) random_sample();
		end_burst();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (120) random_sample();
		end_burst();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deadzone_extremes();
		test_random_phase(200, 0, 0, 15'd7849);
		test_random_phase(180, 84, 0, 15'($urandom_range(32767)));
		test_random_phase(180, 0, 84, 15'd0);
		test_random_phase(180, 34, 34, 15'd32766);
		test_backpressure();
		$display("Covered corner samples, deadzone settings 0..32767 and %0d results",
			results_seen);
		$display("under sender gaps, receiver stalls and a %0d-cycle hold-off", HOLD_LEN);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/jpd_pkg.sv
hw/rtl/jpd_delay.sv
hw/rtl/jpd_sqrt.sv
hw/rtl/jpd_div.sv
hw/rtl/jpd_cordic.sv
hw/rtl/joystick_polar_deadzone.sv
verif/testbench.sv
